// ----- rtl/core/rmslvl_pkg.sv -----
// ============================================================================
// rmslvl_pkg
// Shared types and constants of the block RMS level meter: field widths,
// register map, sequencer states and the configuration bundle.
// ============================================================================
`default_nettype none

package rmslvl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TS_W     = 48;
    localparam int SCALE_W  = 40;
    localparam int FRAME_W  = 24;
    localparam int LEVEL_W  = 16;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 64;

    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 20;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = TS_W + SCALE_W;
    localparam int FRAC_W   = 32;
    localparam int IDX_W    = ACC_W - FRAC_W;
    localparam int ROOT_W   = 32;
    localparam int SQRT_ITERS = ROOT_W / 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h8000;

    localparam logic REG_FRAME_SCALE = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_DIV,
        ST_SQRT,
        ST_MUL_ISSUE,
        ST_MUL_ACC,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [SCALE_W-1:0] frame_scale;
        logic [FRAME_W-1:0] frame_count;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/rmslvl_in_if.sv -----
// ============================================================================
// rmslvl_in_if
// Sample channel: valid/ready handshake with one audio sample per transfer.
// ============================================================================
`default_nettype none

interface rmslvl_in_if;
    import rmslvl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [TS_W-1:0]     block_timestamp;
    logic                       last_in_block;

    modport source (
        output valid, sample, block_timestamp, last_in_block,
        input  ready
    );

    modport sink (
        input  valid, sample, block_timestamp, last_in_block,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/rmslvl_out_if.sv -----
// ============================================================================
// rmslvl_out_if
// Level channel: valid/ready handshake with one frame level per transfer.
// ============================================================================
`default_nettype none

interface rmslvl_out_if;
    import rmslvl_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] video_frame;
    logic [LEVEL_W-1:0] level;
    logic               new_frame;

    modport source (
        output valid, video_frame, level, new_frame,
        input  ready
    );

    modport sink (
        input  valid, video_frame, level, new_frame,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/rmslvl_apb_regs.sv -----
// ============================================================================
// rmslvl_apb_regs
// APB register file holding the frame scale and the frame count.
// ============================================================================
`default_nettype none

module rmslvl_apb_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rmslvl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rmslvl_pkg::DATA_W-1:0] pwdata,
    output      logic [rmslvl_pkg::DATA_W-1:0] prdata,
    output      logic                         pready,
    output      rmslvl_pkg::t_cfg             o_cfg
);
    import rmslvl_pkg::*;

    logic               reg_sel;
    logic [SCALE_W-1:0] r_scale;
    logic [FRAME_W-1:0] r_count;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
            r_count <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FRAME_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                REG_FRAME_COUNT: r_count <= pwdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FRAME_SCALE: prdata = {{(DATA_W-SCALE_W){1'b0}}, r_scale};
            REG_FRAME_COUNT: prdata = {{(DATA_W-FRAME_W){1'b0}}, r_count};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.frame_scale = r_scale;
    assign o_cfg.frame_count = r_count;

endmodule

`default_nettype wire

// ----- rtl/core/block_rms_level_per_frame.sv -----
// ============================================================================
// block_rms_level_per_frame
// Block RMS level meter with per-video-frame peak hold.
//
// Samples arrive on i_in, one per transfer; last_in_block closes a block.
// Each sample takes three steps (accept, square on the shared multiplier,
// accumulate); ready is low from a transfer until the sample is summed.
// On the last sample a sequencer then runs, on one shared datapath:
//   restoring division of the square sum by the sample count,
//   clog2(MAX_BLOCK_SAMPLES+1)+31 quotient bits (45 at the default),
//   a digit-by-digit square root to 16 result bits,
//   four 24x20 partial products for timestamp times frame scale,
//   a last step to range-check the frame index and update the held level.
// Ready returns when the sequence ends. A result goes to an output register
// on o_out; a new sample is taken while it waits, but a following block end
// holds in its last step until the receiver takes the pending result.
// Frame scale (byte address 0) and frame count (byte address 8) are written
// over the APB port, 64-bit data; the user is to write them only while the
// block is idle, which the block itself does not enforce.
// Reset clears the sums, the held level, the previous frame and both
// registers, and drops any pending result.
// ============================================================================
`default_nettype none

module block_rms_level_per_frame #(
    parameter int MAX_BLOCK_SAMPLES = 8192
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rmslvl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rmslvl_pkg::DATA_W-1:0] pwdata,
    output      logic [rmslvl_pkg::DATA_W-1:0] prdata,
    output      logic                          pready,
    rmslvl_in_if.sink                          i_in,
    rmslvl_out_if.source                       o_out
);
    import rmslvl_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W = CNT_W + 31;
    localparam int IT_W  = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCK_SAMPLES);
    localparam logic [IT_W-1:0]  DIV_LAST = IT_W'(SUM_W - 1);
    localparam logic [IT_W-1:0]  SQ_LAST  = IT_W'(SQRT_ITERS - 1);
    localparam logic [IT_W-1:0]  MUL_LAST = IT_W'(3);

    t_cfg cfg;

    t_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_abs, n_abs;
    logic                r_last, n_last;
    logic                r_neg, n_neg;
    logic [TS_W-1:0]     r_mag, n_mag;
    logic [MUL_P_W-1:0]  r_prod, n_prod;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SUM_W-1:0]    r_div, n_div;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [IT_W-1:0]     r_iter, n_iter;
    logic [ROOT_W-1:0]   r_val, n_val;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [ROOT_W-1:0]   r_bit, n_bit;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [LEVEL_W-1:0]  r_level, n_level;
    logic                r_prev_valid, n_prev_valid;
    logic [FRAME_W-1:0]  r_prev, n_prev;
    logic [LEVEL_W-1:0]  r_held, n_held;
    logic                r_out_valid, n_out_valid;
    logic [FRAME_W-1:0]  r_out_frame, n_out_frame;
    logic [LEVEL_W-1:0]  r_out_level, n_out_level;
    logic                r_out_new, n_out_new;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W:0]      rem_sh;
    logic                div_ge;
    logic [CNT_W:0]      rem_sub;
    logic [SUM_W-1:0]    div_shift;
    logic [ROOT_W-1:0]   sq_trial;
    logic                sq_ge;
    logic [ROOT_W-1:0]   root_next;
    logic [ACC_W-1:0]    pp_shifted;
    logic [IDX_W-1:0]    idx;
    logic                in_range;
    logic                fresh;
    logic                out_free;
    logic [LEVEL_W-1:0]  held_next;

    rmslvl_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // shared multiplier operand select
    always_comb begin
        if (r_state == ST_SQ_MUL) begin
            mul_a = {{(MUL_A_W-SAMPLE_W){1'b0}}, r_abs};
            mul_b = {{(MUL_B_W-SAMPLE_W){1'b0}}, r_abs};
        end else begin
            mul_a = r_iter[1] ? r_mag[TS_W-1:MUL_A_W] : r_mag[MUL_A_W-1:0];
            mul_b = r_iter[0] ? cfg.frame_scale[SCALE_W-1:MUL_B_W]
                              : cfg.frame_scale[MUL_B_W-1:0];
        end
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    assign sum_add   = r_sum + SUM_W'(r_prod);
    assign rem_sh    = {r_rem, r_div[SUM_W-1]};
    assign div_ge    = rem_sh >= {1'b0, r_cnt};
    assign rem_sub   = div_ge ? (rem_sh - {1'b0, r_cnt}) : rem_sh;
    assign div_shift = {r_div[SUM_W-2:0], div_ge};

    assign sq_trial  = r_root + r_bit;
    assign sq_ge     = r_val >= sq_trial;
    assign root_next = sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    always_comb begin
        case (r_iter[1:0])
            2'd0:    pp_shifted = ACC_W'(r_prod);
            2'd1:    pp_shifted = ACC_W'(r_prod) << MUL_B_W;
            2'd2:    pp_shifted = ACC_W'(r_prod) << MUL_A_W;
            default: pp_shifted = ACC_W'(r_prod) << (MUL_A_W + MUL_B_W);
        endcase
    end

    assign idx       = r_acc[ACC_W-1:FRAC_W];
    assign in_range  = !(r_neg && (idx != '0))
                       && (idx < {{(IDX_W-FRAME_W){1'b0}}, cfg.frame_count});
    assign fresh     = !r_prev_valid || (r_prev != idx[FRAME_W-1:0]);
    assign held_next = fresh ? r_level : ((r_level > r_held) ? r_level : r_held);
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        n_state      = r_state;
        n_abs        = r_abs;
        n_last       = r_last;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_prod       = r_prod;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_div        = r_div;
        n_rem        = r_rem;
        n_iter       = r_iter;
        n_val        = r_val;
        n_root       = r_root;
        n_bit        = r_bit;
        n_acc        = r_acc;
        n_level      = r_level;
        n_prev_valid = r_prev_valid;
        n_prev       = r_prev;
        n_held       = r_held;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_frame  = r_out_frame;
        n_out_level  = r_out_level;
        n_out_new    = r_out_new;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_abs   = i_in.sample[SAMPLE_W-1] ? SAMPLE_W'(-i_in.sample)
                                                      : SAMPLE_W'(i_in.sample);
                    n_last  = i_in.last_in_block;
                    n_neg   = i_in.block_timestamp[TS_W-1];
                    n_mag   = i_in.block_timestamp[TS_W-1]
                              ? TS_W'(-i_in.block_timestamp)
                              : TS_W'(i_in.block_timestamp);
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                n_prod  = mul_p;
                n_state = ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                if (r_cnt < CNT_MAX) begin
                    n_sum = sum_add;
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_last) begin
                    n_div   = (r_cnt < CNT_MAX) ? sum_add : r_sum;
                    n_sum   = '0;
                    n_rem   = '0;
                    n_iter  = DIV_LAST;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_rem  = rem_sub[CNT_W-1:0];
                n_div  = div_shift;
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_val   = div_shift[ROOT_W-1:0];
                    n_cnt   = '0;
                    n_root  = '0;
                    n_bit   = ROOT_W'(1) << (ROOT_W - 2);
                    n_iter  = SQ_LAST;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    n_val = r_val - sq_trial;
                end
                n_root = root_next;
                n_bit  = r_bit >> 2;
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_level = root_next[LEVEL_W-1:0];
                    n_acc   = '0;
                    n_iter  = MUL_LAST;
                    n_state = ST_MUL_ISSUE;
                end
            end
            ST_MUL_ISSUE: begin
                n_prod  = mul_p;
                n_state = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                n_acc = r_acc + pp_shifted;
                if (r_iter == '0) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_iter  = r_iter - 1'b1;
                    n_state = ST_MUL_ISSUE;
                end
            end
            ST_DECIDE: begin
                if (!in_range) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_prev_valid = 1'b1;
                    n_prev       = idx[FRAME_W-1:0];
                    n_held       = held_next;
                    n_out_valid  = 1'b1;
                    n_out_frame  = idx[FRAME_W-1:0];
                    n_out_level  = held_next;
                    n_out_new    = fresh;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_cnt        <= '0;
            r_prev_valid <= 1'b0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
            r_prev_valid <= n_prev_valid;
            r_held       <= n_held;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_abs       <= n_abs;
        r_last      <= n_last;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_prod      <= n_prod;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_iter      <= n_iter;
        r_val       <= n_val;
        r_root      <= n_root;
        r_bit       <= n_bit;
        r_acc       <= n_acc;
        r_level     <= n_level;
        r_prev      <= n_prev;
        r_out_frame <= n_out_frame;
        r_out_level <= n_out_level;
        r_out_new   <= n_out_new;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.video_frame = r_out_frame;
    assign o_out.level       = r_out_level;
    assign o_out.new_frame   = r_out_new;

endmodule

`default_nettype wire

// ----- rtl/core/rmslvl_checker.sv -----
// ============================================================================
// rmslvl_checker
// Port-level checks of the RMS level meter, bound to the top level.
// ============================================================================
`default_nettype none

module rmslvl_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [rmslvl_pkg::FRAME_W-1:0] i_out_frame,
    input wire logic [rmslvl_pkg::LEVEL_W-1:0] i_out_level,
    input wire logic                           i_out_new
);
    import rmslvl_pkg::*;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample channel ready right after a transfer");

    a_no_result_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after a sample transfer");

    a_hold_stalled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_frame)
            && $stable(i_out_level) && $stable(i_out_new))
        else $error("stalled result changed or dropped");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_level <= LEVEL_MAX)
        else $error("level above full scale");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind block_rms_level_per_frame rmslvl_checker u_rmslvl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_frame (o_out.video_frame),
    .i_out_level (o_out.level),
    .i_out_new   (o_out.new_frame)
);

`default_nettype wire
